/* rtl/gnce_pkg.sv */
// Shared types, constants and helpers of the grid neighbour cell enumerator.
// Depends on nothing; every module of the block imports it.
package gnce_pkg;

   localparam int CELL_W      = 20;   // linear cell index
   localparam int DIM_W       = 11;   // column and row count registers
   localparam int POS_W       = 10;   // column or row position inside the grid
   localparam int QUO_W       = 10;   // quotient bits (row) produced by the divider
   localparam int DIV_STAGES  = QUO_W / 2;
   localparam int NUM_CAND    = 9;    // 3 x 3 candidate window
   localparam int CAND_W      = 4;
   localparam int CSR_IDX_W   = 2;

   localparam logic [DIM_W-1:0] MAX_COLUMNS   = DIM_W'(1024);
   localparam logic [DIM_W-1:0] MAX_ROWS      = DIM_W'(1024);
   localparam logic [DIM_W-1:0] RESET_COLUMNS = DIM_W'(64);
   localparam logic [DIM_W-1:0] RESET_ROWS    = DIM_W'(64);

   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LARGER_ONLY = 2'd2;

   // One word in flight through the divider pipeline.
   typedef struct packed {
      logic [CELL_W-1:0] centre;
      logic [CELL_W-1:0] rem;
      logic [QUO_W-1:0]  quo;
      logic              oor;
   } stage_type;

   // Candidate set handed from the pipeline to the emitter.
   typedef struct packed {
      logic [NUM_CAND-1:0] mask;
      logic [CELL_W-1:0]   centre;
      logic [DIM_W-1:0]    cols;
      logic                oor;
   } cand_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] maxv);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) r = DIM_W'(1);
      else if (v > maxv) r = maxv;
      return r;
   endfunction

   // Candidate c has x offset c/3-1 and y offset c%3-1.
   function automatic logic cand_xm(input logic [CAND_W-1:0] c);
      return c < CAND_W'(3);
   endfunction

   function automatic logic cand_xp(input logic [CAND_W-1:0] c);
      return c >= CAND_W'(6);
   endfunction

   function automatic logic cand_ym(input logic [CAND_W-1:0] c);
      return (c == CAND_W'(0)) || (c == CAND_W'(3)) || (c == CAND_W'(6));
   endfunction

   function automatic logic cand_yp(input logic [CAND_W-1:0] c);
      return (c == CAND_W'(2)) || (c == CAND_W'(5)) || (c == CAND_W'(8));
   endfunction

endpackage

/* rtl/gnce_emit.sv */
// Result emitter: walks a candidate set one neighbour per cycle and drives
// the registered result ports. Depends on gnce_pkg.
module gnce_emit import gnce_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              load_valid,
   input  cand_type          load_cand,
   output logic              free,
   output logic              rsp_strobe,
   output logic [CELL_W-1:0] rsp_neighbour_index,
   output logic              rsp_last,
   output logic              rsp_none_found,
   output logic              rsp_out_of_range
);

   logic                busy_ff, busy_in;
   cand_type            cur_ff, cur_in;
   logic [CAND_W-1:0]   sel;
   logic [NUM_CAND-1:0] rest;
   logic                last_now;
   logic [CELL_W:0]     row_off, col_off, sum;

   logic              strobe_ff, strobe_in;
   logic [CELL_W-1:0] idx_ff, idx_in;
   logic              last_ff, last_in;
   logic              none_ff, none_in;
   logic              oor_ff, oor_in;

   // pick the lowest pending candidate
   always_comb begin
      sel = '0;
      for (int c = NUM_CAND - 1; c >= 0; c--) begin
         if (cur_ff.mask[c]) sel = CAND_W'(c);
      end
      rest     = cur_ff.mask & ~(NUM_CAND'(1) << sel);
      last_now = (rest == '0);
      free     = !busy_ff || last_now;
   end

   // neighbour = centre + dx + dy * columns
   always_comb begin
      row_off = '0;
      if (cand_yp(sel)) row_off = {{(CELL_W+1-DIM_W){1'b0}}, cur_ff.cols};
      else if (cand_ym(sel)) row_off = -{{(CELL_W+1-DIM_W){1'b0}}, cur_ff.cols};
      col_off = '0;
      if (cand_xp(sel)) col_off = (CELL_W+1)'(1);
      else if (cand_xm(sel)) col_off = '1;
      sum = {1'b0, cur_ff.centre} + row_off + col_off;
   end

   always_comb begin
      busy_in = busy_ff;
      cur_in  = cur_ff;
      if (free) begin
         busy_in = load_valid;
         cur_in  = load_cand;
      end else begin
         cur_in.mask = rest;
      end

      strobe_in = busy_ff;
      last_in   = last_now;
      if (cur_ff.mask == '0) begin
         idx_in  = '0;
         none_in = !cur_ff.oor;
         oor_in  = cur_ff.oor;
      end else begin
         idx_in  = sum[CELL_W-1:0];
         none_in = 1'b0;
         oor_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         strobe_ff <= strobe_in;
      end
      cur_ff  <= cur_in;
      idx_ff  <= idx_in;
      last_ff <= last_in;
      none_ff <= none_in;
      oor_ff  <= oor_in;
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_neighbour_index = idx_ff;
   assign rsp_last            = last_ff;
   assign rsp_none_found      = none_ff;
   assign rsp_out_of_range    = oor_ff;

endmodule

/* rtl/grid_neighbour_cell_enumerator.sv */
// Top level of the grid neighbour cell enumerator: config registers, the
// range check and the pipelined divider. Depends on gnce_pkg and gnce_emit.
//
// Usage
//   A word enters on req_cell_index at a rising edge where start is high and
//   busy is low. For each word the block returns its in-bounds neighbours in
//   the order x offset outer, y offset inner, one result per cycle on the rsp_
//   ports, each marked by rsp_strobe for exactly one cycle; rsp_last flags the
//   final result of a word. An index at or beyond columns * rows yields one
//   result with rsp_out_of_range; a cell without a qualifying neighbour yields
//   one result with rsp_none_found.
//   The first result reaches the rsp_ ports through the input register, five
//   divider stages of two quotient bits each, the candidate register and the
//   output register. The result port sets the pace: a word with n results
//   (1 to 8) keeps the emitter until it has issued all of them. busy rises while
//   a word waits at the divider output for the emitter to finish the previous
//   word; the whole pipeline holds meanwhile. Words with a single result can
//   follow every cycle.
//   Write csr_ registers only while no word is in flight. Reset clears all
//   pipeline valid bits and loads 64 x 64 cells, larger_only 0.
//   The receiver cannot stall; results are never held back.
module grid_neighbour_cell_enumerator import gnce_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [CELL_W-1:0]    req_cell_index,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_write_data,
   output logic                 rsp_strobe,
   output logic [CELL_W-1:0]    rsp_neighbour_index,
   output logic                 rsp_last,
   output logic                 rsp_none_found,
   output logic                 rsp_out_of_range
);

   // configuration registers
   logic [DIM_W-1:0] columns_ff, columns_in;
   logic [DIM_W-1:0] rows_ff, rows_in;
   logic             larger_only_ff, larger_only_in;
   logic [DIM_W-1:0] cols_c, rows_c;
   logic [CELL_W:0]  cells_ff, cells_in;   // columns * rows, at most 2^20

   always_comb begin
      columns_in     = columns_ff;
      rows_in        = rows_ff;
      larger_only_in = larger_only_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_COLUMNS:     columns_in     = csr_write_data;
            CSR_ROWS:        rows_in        = csr_write_data;
            CSR_LARGER_ONLY: larger_only_in = csr_write_data[0];
            default: ;   // drop writes to unknown registers
         endcase
      end
      cols_c   = clamp_dim(columns_ff, MAX_COLUMNS);
      rows_c   = clamp_dim(rows_ff, MAX_ROWS);
      cells_in = {{(CELL_W+1-DIM_W){1'b0}}, cols_c} *
                 {{(CELL_W+1-DIM_W){1'b0}}, rows_c};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff     <= RESET_COLUMNS;
         rows_ff        <= RESET_ROWS;
         larger_only_ff <= 1'b0;
      end else begin
         columns_ff     <= columns_in;
         rows_ff        <= rows_in;
         larger_only_ff <= larger_only_in;
      end
      cells_ff <= cells_in;
   end

   // divider pipeline: stage 0 is the input register, stages 1..5 each
   // retire two quotient bits of cell / columns
   logic [DIV_STAGES:0] v_ff, v_in;
   stage_type           st_ff [0:DIV_STAGES];
   stage_type           st_in [0:DIV_STAGES];
   logic                adv;
   logic                emit_free;

   assign adv  = !v_ff[DIV_STAGES] || emit_free;
   assign busy = !adv;

   always_comb begin
      st_in[0].centre = req_cell_index;
      st_in[0].rem    = req_cell_index;
      st_in[0].quo    = '0;
      st_in[0].oor    = 1'b0;
      v_in = {v_ff[DIV_STAGES-1:0], start};
   end

   for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
      localparam int SH_HI = QUO_W - 2 * k + 1;
      localparam int SH_LO = QUO_W - 2 * k;
      logic [CELL_W:0] d_hi, d_lo, r0, r1;
      logic            q_hi, q_lo;

      always_comb begin
         d_hi = {{(CELL_W+1-DIM_W){1'b0}}, cols_c} << SH_HI;
         d_lo = {{(CELL_W+1-DIM_W){1'b0}}, cols_c} << SH_LO;
         r0   = {1'b0, st_ff[k-1].rem};
         q_hi = (r0 >= d_hi);
         if (q_hi) r0 = r0 - d_hi;
         q_lo = (r0 >= d_lo);
         r1   = q_lo ? r0 - d_lo : r0;
         st_in[k].centre = st_ff[k-1].centre;
         st_in[k].rem    = r1[CELL_W-1:0];
         st_in[k].quo    = {st_ff[k-1].quo[QUO_W-3:0], q_hi, q_lo};
         // the range check runs beside the first divider stage
         if (k == 1) st_in[k].oor = ({1'b0, st_ff[k-1].centre} >= cells_ff);
         else        st_in[k].oor = st_ff[k-1].oor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
      if (adv) begin
         for (int i = 0; i <= DIV_STAGES; i++) st_ff[i] <= st_in[i];
      end
   end

   // candidate window from column x = remainder and row y = quotient
   cand_type          cand;
   logic [POS_W-1:0]  pos_x, pos_y;
   logic              x_lo, x_hi, y_lo, y_hi;
   logic [CAND_W-1:0] cc;
   logic              keep;

   always_comb begin
      pos_x = st_ff[DIV_STAGES].rem[POS_W-1:0];
      pos_y = st_ff[DIV_STAGES].quo;
      x_lo  = (pos_x == '0);
      y_lo  = (pos_y == '0);
      x_hi  = ({1'b0, pos_x} + DIM_W'(1)) >= cols_c;
      y_hi  = ({1'b0, pos_y} + DIM_W'(1)) >= rows_c;
      cand.centre = st_ff[DIV_STAGES].centre;
      cand.cols   = cols_c;
      cand.oor    = st_ff[DIV_STAGES].oor;
      for (int c = 0; c < NUM_CAND; c++) begin
         cc   = CAND_W'(c);
         keep = !(cand_xm(cc) && x_lo) && !(cand_xp(cc) && x_hi) &&
                !(cand_ym(cc) && y_lo) && !(cand_yp(cc) && y_hi);
         // in bounds, a larger index means a row below, or same row to the right
         if (larger_only_ff)
            keep = keep && (cand_yp(cc) ||
                            (!cand_ym(cc) && cand_xp(cc)));
         else
            keep = keep && (cand_xm(cc) || cand_xp(cc) ||
                            cand_ym(cc) || cand_yp(cc));
         cand.mask[c] = keep && !st_ff[DIV_STAGES].oor;
      end
   end

   gnce_emit u_emit (
      .clock               (clock),
      .reset               (reset),
      .load_valid          (v_ff[DIV_STAGES]),
      .load_cand           (cand),
      .free                (emit_free),
      .rsp_strobe          (rsp_strobe),
      .rsp_neighbour_index (rsp_neighbour_index),
      .rsp_last            (rsp_last),
      .rsp_none_found      (rsp_none_found),
      .rsp_out_of_range    (rsp_out_of_range)
   );

   // flagged results are always single and carry a zero index
   a_flag_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_none_found || rsp_out_of_range) |->
         rsp_last && (rsp_neighbour_index == '0))
      else $error("flagged result is not a lone final word");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_none_found && rsp_out_of_range))
      else $error("none_found and out_of_range both set");

   // the results of one word come out back to back
   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe)
      else $error("gap inside a result burst");

   // the front end only stalls while a word waits at the divider output
   a_stall: assert property (@(posedge clock) disable iff (reset)
      busy |-> v_ff[DIV_STAGES])
      else $error("busy without a word waiting for the emitter");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the grid neighbour cell enumerator: directed and random
// cell words, a local neighbour predictor and a result checker. Depends on gnce_pkg.
module tb import gnce_pkg::*; ();

   // Register index past the three real registers; writes to it must be dropped.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int RESULT_LATENCY = 8;
   localparam int CYCLE_LIMIT    = 250000;
   localparam int PHASE_WORDS    = 45;

   // One result word as the block should present it.
   typedef struct packed {
      logic [CELL_W-1:0] neighbour;
      logic              last;
      logic              none_found;
      logic              out_of_range;
   } nbr_word_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [CELL_W-1:0]    req_cell_index;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DIM_W-1:0]     csr_write_data;
   logic                 rsp_strobe;
   logic [CELL_W-1:0]    rsp_neighbour_index;
   logic                 rsp_last;
   logic                 rsp_none_found;
   logic                 rsp_out_of_range;

   // Predictor copy of the configuration registers.
   logic [DIM_W-1:0] grid_columns;
   logic [DIM_W-1:0] grid_rows;
   logic             larger_only;

   nbr_word_type neighbours_due[$];   // predicted results not yet seen on rsp_
   nbr_word_type oldest_due;
   int           mismatches = 0;
   int           cycle_count = 0;
   int           sender_idle_pct = 0;

   grid_neighbour_cell_enumerator dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_cell_index      (req_cell_index),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .rsp_strobe          (rsp_strobe),
      .rsp_neighbour_index (rsp_neighbour_index),
      .rsp_last            (rsp_last),
      .rsp_none_found      (rsp_none_found),
      .rsp_out_of_range    (rsp_out_of_range)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Effective grid dimension: zero reads as one, anything past the maximum as the maximum.
   function automatic int grid_dim(input logic [DIM_W-1:0] raw, input logic [DIM_W-1:0] maxv);
      if (raw == '0) return 1;
      if (raw > maxv) return int'(maxv);
      return int'(raw);
   endfunction

   // Work out the neighbour words of one accepted cell and queue them in emit order.
   function automatic void predict_neighbours(input logic [CELL_W-1:0] centre);
      int           cols;
      int           rws;
      int           cx;
      int           cy;
      int           nx;
      int           ny;
      int           nidx;
      bit           take;
      nbr_word_type found[$];
      cols = grid_dim(grid_columns, MAX_COLUMNS);
      rws  = grid_dim(grid_rows, MAX_ROWS);
      if (int'(centre) >= cols * rws) begin
         neighbours_due.push_back('{neighbour: '0, last: 1'b1, none_found: 1'b0,
                                    out_of_range: 1'b1});
         return;
      end
      cx = int'(centre) % cols;
      cy = (int'(centre) / cols) % rws;
      // x offset in the outer loop, y offset in the inner loop, each -1..+1
      for (int c = 0; c < NUM_CAND; c++) begin
         nx = cx + c / 3 - 1;
         ny = cy + c % 3 - 1;
         if (nx < 0 || nx >= cols || ny < 0 || ny >= rws) continue;
         nidx = nx + ny * cols;
         take = larger_only ? (nidx > int'(centre)) : (nidx != int'(centre));
         if (take)
            found.push_back('{neighbour: CELL_W'(nidx), last: 1'b0, none_found: 1'b0,
                              out_of_range: 1'b0});
      end
      if (found.size() == 0) begin
         neighbours_due.push_back('{neighbour: '0, last: 1'b1, none_found: 1'b1,
                                    out_of_range: 1'b0});
      end else begin
         found[found.size() - 1].last = 1'b1;
         foreach (found[i]) neighbours_due.push_back(found[i]);
      end
   endfunction

   // Pick a cell word: mostly inside the grid, biased to its border, some past the end.
   function automatic logic [CELL_W-1:0] pick_cell();
      int cols;
      int rws;
      int total;
      int pick;
      cols  = grid_dim(grid_columns, MAX_COLUMNS);
      rws   = grid_dim(grid_rows, MAX_ROWS);
      total = cols * rws;
      pick  = $urandom_range(99);
      if (pick < 12) return CELL_W'($urandom);
      if (pick < 20) return CELL_W'(total + $urandom_range(3));
      if (pick < 45) begin
         if ($urandom_range(1))
            return CELL_W'(($urandom_range(1) ? cols - 1 : 0) + $urandom_range(rws - 1) * cols);
         return CELL_W'($urandom_range(cols - 1) + ($urandom_range(1) ? rws - 1 : 0) * cols);
      end
      return CELL_W'($urandom_range(total - 1));
   endfunction

   // Pick a raw dimension register value; small grids dominate, extremes show up often.
   function automatic logic [DIM_W-1:0] pick_dim();
      case ($urandom_range(9))
         0:       return '0;
         1:       return DIM_W'(1);
         2:       return DIM_W'(2);
         3:       return MAX_COLUMNS;
         4:       return DIM_W'($urandom_range(1025, 2047));
         5, 6:    return DIM_W'($urandom_range(3, 16));
         default: return DIM_W'($urandom_range(1, 1024));
      endcase
   endfunction

   // Drop start and hold until every predicted word has come back, then let the pipe settle.
   task automatic wait_until_drained();
      start <= 1'b0;
      while (neighbours_due.size() != 0) @(posedge clock);
      repeat (RESULT_LATENCY) @(posedge clock);
   endtask

   // Write one register with the block idle and mirror it in the predictor.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
      wait_until_drained();
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         CSR_COLUMNS:     grid_columns = data;
         CSR_ROWS:        grid_rows = data;
         CSR_LARGER_ONLY: larger_only = data[0];
         default:         ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic configure_grid(input logic [DIM_W-1:0] cols, input logic [DIM_W-1:0] rws,
                                 input logic mode);
      write_register(CSR_COLUMNS, cols);
      write_register(CSR_ROWS, rws);
      write_register(CSR_LARGER_ONLY, DIM_W'(mode));
   endtask

   // Offer one cell word after a random idle gap; predict at the edge that accepts it.
   // Leave start high on return so back-to-back words need no second assignment.
   task automatic send_cell(input logic [CELL_W-1:0] centre);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_cell_index <= centre;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_neighbours(centre);
   endtask

   task automatic check_field(input string name, input int want_v, input int got_v);
      if (want_v != got_v) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
         mismatches++;
      end
   endtask

   // Results cannot be held off: take every strobed word against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (neighbours_due.size() == 0) begin
            $display("%0t: unexpected word, neighbour %0d last %b none_found %b out_of_range %b",
                     $time, rsp_neighbour_index, rsp_last, rsp_none_found, rsp_out_of_range);
            mismatches++;
         end else begin
            oldest_due = neighbours_due.pop_front();
            check_field("neighbour_index", oldest_due.neighbour, rsp_neighbour_index);
            check_field("last", oldest_due.last, rsp_last);
            check_field("none_found", oldest_due.none_found, rsp_none_found);
            check_field("out_of_range", oldest_due.out_of_range, rsp_out_of_range);
         end
      end
   end

   // Watchdog: abort a run that hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Reset grid of 64 x 64: corners, an interior cell and indexes past the end.
   task automatic test_reset_grid();
      send_cell(20'd0);
      send_cell(20'd63);
      send_cell(20'd4032);
      send_cell(20'd4095);
      send_cell(20'd65);
      send_cell(20'd4096);
      send_cell(20'hFFFFF);
   endtask

   // Larger-only mode: the highest cell has nothing above it.
   task automatic test_larger_only();
      write_register(CSR_LARGER_ONLY, DIM_W'(1));
      send_cell(20'd0);
      send_cell(20'd65);
      send_cell(20'd4094);
      send_cell(20'd4095);
   endtask

   // Zero and oversized dimension registers, single-cell and single-column grids,
   // and a write to an index with no register behind it.
   task automatic test_degenerate_grids();
      configure_grid('0, DIM_W'(1), 1'b0);
      send_cell(20'd0);
      send_cell(20'd1);
      configure_grid(DIM_W'(1), MAX_ROWS, 1'b0);
      send_cell(20'd0);
      send_cell(20'd500);
      send_cell(20'd1023);
      send_cell(20'd1024);
      configure_grid(DIM_W'(2047), DIM_W'(2047), 1'b0);
      send_cell(20'hFFFFF);
      send_cell(20'd0);
      send_cell(20'd1025);
      write_register(CSR_SPARE, DIM_W'(2047));
      write_register(CSR_SPARE, '0);
      send_cell(20'd1023);
      send_cell(20'hFFBFF);
   endtask

   // Random words over a run of grid settings; the first phase of each call uses an extreme.
   task automatic test_random_traffic(input int first_phase, input int last_phase,
                                      input int idle_pct);
      sender_idle_pct = idle_pct;
      for (int p = first_phase; p < last_phase; p++) begin
         case (p)
            0:       configure_grid(MAX_COLUMNS, MAX_ROWS, 1'b1);
            3:       configure_grid(DIM_W'(1), DIM_W'($urandom_range(2, 1024)), 1'b0);
            6:       configure_grid(DIM_W'($urandom_range(2, 1024)), DIM_W'(1), 1'b1);
            default: configure_grid(pick_dim(), pick_dim(), 1'($urandom_range(1)));
         endcase
         repeat (PHASE_WORDS) send_cell(pick_cell());
      end
   endtask

   // Stop offering words until the block has returned everything, then resume.
   task automatic test_pause_until_drained();
      sender_idle_pct = 0;
      configure_grid(DIM_W'($urandom_range(2, 40)), DIM_W'($urandom_range(2, 40)), 1'b0);
      repeat (10) send_cell(pick_cell());
      wait_until_drained();
      repeat (10) send_cell(pick_cell());
   endtask

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_cell_index   = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_COLUMNS;
      csr_write_data   = '0;
      grid_columns     = RESET_COLUMNS;
      grid_rows        = RESET_ROWS;
      larger_only      = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_grid();
      test_larger_only();
      test_degenerate_grids();
      test_random_traffic(0, 3, 11);
      test_pause_until_drained();
      test_random_traffic(3, 6, 78);
      test_random_traffic(6, 9, 0);

      // Hold until the last predicted word is back, then allow stragglers to show.
      wait_until_drained();
      repeat (2 * RESULT_LATENCY) @(posedge clock);
      if (mismatches == 0 && neighbours_due.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
